>>> design/epdpdr_pkg.sv
// Shared types and constants of the e-paper pixel diff dirty-region tracker.
package epdpdr_pkg;

    // Port widths fixed by the pixel and region formats
    localparam int LX_W    = 9;
    localparam int LY_W    = 10;
    localparam int COLOR_W = 24;
    localparam int RX_W    = 10;
    localparam int RY_W    = 9;
    localparam int RW_W    = 10;
    localparam int RH_W    = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FORMAT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THRESHOLD = 1'd1;
    localparam logic                 COLOR_FORMAT_RESET  = 1'b0;
    localparam logic [7:0]           THRESHOLD_RESET     = 8'd128;

    // Colour encodings
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB888 = 1'b1;

    // Frame store word organisation: 64 pixels to a word
    localparam int WORD_BITS = 64;
    localparam int WORD_SEL  = 6;

    // Queue depths
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

    // Classification of one pixel word
    typedef struct packed {
        logic on_screen;
        logic black;
        logic area_end;
        logic flush_end;
    } t_pix_flags;

    // One changed rectangle
    typedef struct packed {
        logic [RX_W-1:0] region_x;
        logic [RY_W-1:0] region_y;
        logic [RW_W-1:0] region_width;
        logic [RH_W-1:0] region_height;
    } t_region;

endpackage

>>> design/epdpdr_fifo.sv
// Small flip-flop queue with occupancy count.
module epdpdr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic             o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_data[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

endmodule

>>> design/epdpdr_front.sv
// Front end: brightness test, rotation to panel position and store address.
module epdpdr_front #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic [epdpdr_pkg::LX_W-1:0]    i_logical_x,
    input  logic [epdpdr_pkg::LY_W-1:0]    i_logical_y,
    input  logic [epdpdr_pkg::COLOR_W-1:0] i_pixel_color,
    input  logic                           i_area_end,
    input  logic                           i_flush_end,
    input  logic                           i_color_format,
    input  logic [7:0]                     i_black_threshold,
    output epdpdr_pkg::t_pix_flags         o_flags,
    output logic [$clog2(PANEL_WIDTH+1)-1:0]  o_px,
    output logic [$clog2(PANEL_HEIGHT+1)-1:0] o_py,
    output logic [((PANEL_HEIGHT*((PANEL_WIDTH+epdpdr_pkg::WORD_BITS-1)/
                   epdpdr_pkg::WORD_BITS)) > 1 ?
                  $clog2(PANEL_HEIGHT*((PANEL_WIDTH+epdpdr_pkg::WORD_BITS-1)/
                   epdpdr_pkg::WORD_BITS)) : 1)-1:0] o_addr,
    output logic [epdpdr_pkg::WORD_SEL-1:0] o_bit
);

    localparam int PXW       = $clog2(PANEL_WIDTH + 1);
    localparam int PYW       = $clog2(PANEL_HEIGHT + 1);
    localparam int WS        = epdpdr_pkg::WORD_SEL;
    localparam int ROW_WORDS = (PANEL_WIDTH + epdpdr_pkg::WORD_BITS - 1) / epdpdr_pkg::WORD_BITS;
    localparam int MEM_DEPTH = PANEL_HEIGHT * ROW_WORDS;
    localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic           on_screen;
    logic [PXW-1:0] px;
    logic [PYW-1:0] py;
    logic [9:0]     luma_x3;
    logic [9:0]     thr_x3;

    assign on_screen = (32'(i_logical_x) < 32'(PANEL_HEIGHT)) &&
                       (32'(i_logical_y) < 32'(PANEL_WIDTH));

    // Rotate clockwise: panel column counts down from the right edge
    assign px = PXW'(PANEL_WIDTH - 1) - PXW'(i_logical_y);
    assign py = PYW'(i_logical_x);

    // Compare three times the brightness against three times the threshold
    always_comb begin
        if (i_color_format == epdpdr_pkg::FMT_RGB888) begin
            luma_x3 = 10'(i_pixel_color[23:16]) + 10'(i_pixel_color[15:8]) +
                      10'(i_pixel_color[7:0]);
        end else begin
            luma_x3 = 10'({i_pixel_color[15:11], 3'b000}) +
                      10'({i_pixel_color[10:5], 2'b00}) +
                      10'({i_pixel_color[4:0], 3'b000});
        end
    end

    assign thr_x3 = 10'({i_black_threshold, 1'b0}) + 10'(i_black_threshold);

    always_comb begin
        o_flags.on_screen = on_screen;
        o_flags.black     = (luma_x3 < thr_x3);
        o_flags.area_end  = i_area_end;
        o_flags.flush_end = i_flush_end;
    end

    assign o_px   = px;
    assign o_py   = py;
    assign o_addr = MAW'(32'(py) * 32'(ROW_WORDS) + 32'(px >> WS));
    assign o_bit  = WS'(px);

endmodule

>>> design/epdpdr_back.sv
// Back end: frame store read-modify-write, area bounds and batch box merge.
module epdpdr_back #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  epdpdr_pkg::t_pix_flags                i_flags,
    input  logic [$clog2(PANEL_WIDTH+1)-1:0]      i_px,
    input  logic [$clog2(PANEL_HEIGHT+1)-1:0]     i_py,
    input  logic [((PANEL_HEIGHT*((PANEL_WIDTH+epdpdr_pkg::WORD_BITS-1)/
                   epdpdr_pkg::WORD_BITS)) > 1 ?
                  $clog2(PANEL_HEIGHT*((PANEL_WIDTH+epdpdr_pkg::WORD_BITS-1)/
                   epdpdr_pkg::WORD_BITS)) : 1)-1:0] i_addr,
    input  logic [epdpdr_pkg::WORD_SEL-1:0]       i_bit,
    output logic                                  o_clearing,
    output logic [1:0]                            o_inflight,
    output logic                                  o_res_valid,
    output epdpdr_pkg::t_region                   o_res
);

    localparam int PXW       = $clog2(PANEL_WIDTH + 1);
    localparam int PYW       = $clog2(PANEL_HEIGHT + 1);
    localparam int WB        = epdpdr_pkg::WORD_BITS;
    localparam int WS        = epdpdr_pkg::WORD_SEL;
    localparam int ROW_WORDS = (PANEL_WIDTH + WB - 1) / WB;
    localparam int MEM_DEPTH = PANEL_HEIGHT * ROW_WORDS;
    localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Frame store
    logic [WB-1:0]  r_mem [MEM_DEPTH];
    logic [WB-1:0]  r_rdata;
    logic           mem_we;
    logic [MAW-1:0] mem_waddr;
    logic [WB-1:0]  mem_wdata;

    logic           r_clearing;
    logic [MAW-1:0] r_clr_addr;

    // Last written word, for a read that raced the write
    logic           r_fwd_valid;
    logic [MAW-1:0] r_fwd_addr;
    logic [WB-1:0]  r_fwd_data;

    // Store stage
    logic                   r_s2_valid;
    epdpdr_pkg::t_pix_flags r_s2_flags;
    logic [PXW-1:0]         r_s2_px;
    logic [PYW-1:0]         r_s2_py;
    logic [MAW-1:0]         r_s2_addr;
    logic [WS-1:0]          r_s2_bit;

    // Open area
    logic           r_area_changed;
    logic [PXW-1:0] r_area_minx, r_area_maxx;
    logic [PYW-1:0] r_area_miny, r_area_maxy;
    logic           n_area_changed;
    logic [PXW-1:0] n_area_minx, n_area_maxx;
    logic [PYW-1:0] n_area_miny, n_area_maxy;

    // Closed area on its way to the batch box
    logic           r_s3_valid;
    logic           r_s3_flush;
    logic           r_s3_changed;
    logic [PXW-1:0] r_s3_lo, r_s3_hi;
    logic [PYW-1:0] r_s3_miny, r_s3_maxy;

    // Batch box
    logic           r_b_changed;
    logic [PXW-1:0] r_b_minx, r_b_maxx;
    logic [PYW-1:0] r_b_miny, r_b_maxy;
    logic           n_b_changed;
    logic [PXW-1:0] n_b_minx, n_b_maxx;
    logic [PYW-1:0] n_b_miny, n_b_maxy;

    // Finished box of a flush
    logic           r_s4_valid;
    logic           r_s4_changed;
    logic [PXW-1:0] r_s4_minx, r_s4_maxx;
    logic [PYW-1:0] r_s4_miny, r_s4_maxy;

    logic           pix_on;
    logic           closing;
    logic [WB-1:0]  word_cur;
    logic [WB-1:0]  word_new;
    logic           stored;
    logic           diff;
    logic [PXW-1:0] lo;
    logic [PXW-1:0] hi_raw;
    logic [PXW-1:0] hi;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_valid) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_comb begin
        word_cur = (r_fwd_valid && (r_fwd_addr == r_s2_addr)) ? r_fwd_data : r_rdata;
        stored   = word_cur[r_s2_bit];
        pix_on   = r_s2_valid && r_s2_flags.on_screen;
        diff     = pix_on && (r_s2_flags.black != stored);
        word_new = word_cur;
        word_new[r_s2_bit] = r_s2_flags.black;
        closing  = r_s2_valid && (r_s2_flags.area_end || r_s2_flags.flush_end);
    end

    assign mem_we    = r_clearing || diff;
    assign mem_waddr = r_clearing ? r_clr_addr : r_s2_addr;
    assign mem_wdata = r_clearing ? '0 : word_new;

    always_comb begin
        n_area_changed = r_area_changed || diff;
        n_area_minx = (pix_on && (r_s2_px < r_area_minx)) ? r_s2_px : r_area_minx;
        n_area_maxx = (pix_on && (r_s2_px > r_area_maxx)) ? r_s2_px : r_area_maxx;
        n_area_miny = (pix_on && (r_s2_py < r_area_miny)) ? r_s2_py : r_area_miny;
        n_area_maxy = (pix_on && (r_s2_py > r_area_maxy)) ? r_s2_py : r_area_maxy;
        // Widen to whole 8-pixel columns, capped at the right edge
        lo     = n_area_minx & ~PXW'(7);
        hi_raw = n_area_maxx | PXW'(7);
        hi     = (hi_raw > PXW'(PANEL_WIDTH - 1)) ? PXW'(PANEL_WIDTH - 1) : hi_raw;
    end

    always_comb begin
        n_b_changed = r_b_changed || r_s3_changed;
        n_b_minx = (r_s3_changed && (r_s3_lo < r_b_minx))     ? r_s3_lo   : r_b_minx;
        n_b_maxx = (r_s3_changed && (r_s3_hi > r_b_maxx))     ? r_s3_hi   : r_b_maxx;
        n_b_miny = (r_s3_changed && (r_s3_miny < r_b_miny))   ? r_s3_miny : r_b_miny;
        n_b_maxy = (r_s3_changed && (r_s3_maxy > r_b_maxy))   ? r_s3_maxy : r_b_maxy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing     <= 1'b1;
            r_clr_addr     <= '0;
            r_fwd_valid    <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
            r_s4_valid     <= 1'b0;
            r_area_changed <= 1'b0;
            r_area_minx    <= PXW'(PANEL_WIDTH);
            r_area_maxx    <= '0;
            r_area_miny    <= PYW'(PANEL_HEIGHT);
            r_area_maxy    <= '0;
            r_b_changed    <= 1'b0;
            r_b_minx       <= PXW'(PANEL_WIDTH);
            r_b_maxx       <= '0;
            r_b_miny       <= PYW'(PANEL_HEIGHT);
            r_b_maxy       <= '0;
        end else begin
            // Sweep the store to white after reset
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + MAW'(1);
                if (r_clr_addr == MAW'(MEM_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (diff) begin
                r_fwd_valid <= 1'b1;
            end
            r_s2_valid <= i_valid;
            r_s3_valid <= closing;
            r_s4_valid <= r_s3_valid && r_s3_flush;

            if (closing) begin
                r_area_changed <= 1'b0;
                r_area_minx    <= PXW'(PANEL_WIDTH);
                r_area_maxx    <= '0;
                r_area_miny    <= PYW'(PANEL_HEIGHT);
                r_area_maxy    <= '0;
            end else begin
                r_area_changed <= n_area_changed;
                r_area_minx    <= n_area_minx;
                r_area_maxx    <= n_area_maxx;
                r_area_miny    <= n_area_miny;
                r_area_maxy    <= n_area_maxy;
            end

            if (r_s3_valid) begin
                if (r_s3_flush) begin
                    r_b_changed <= 1'b0;
                    r_b_minx    <= PXW'(PANEL_WIDTH);
                    r_b_maxx    <= '0;
                    r_b_miny    <= PYW'(PANEL_HEIGHT);
                    r_b_maxy    <= '0;
                end else begin
                    r_b_changed <= n_b_changed;
                    r_b_minx    <= n_b_minx;
                    r_b_maxx    <= n_b_maxx;
                    r_b_miny    <= n_b_miny;
                    r_b_maxy    <= n_b_maxy;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (diff) begin
            r_fwd_addr <= r_s2_addr;
            r_fwd_data <= word_new;
        end
        if (i_valid) begin
            r_s2_flags <= i_flags;
            r_s2_px    <= i_px;
            r_s2_py    <= i_py;
            r_s2_addr  <= i_addr;
            r_s2_bit   <= i_bit;
        end
        if (closing) begin
            r_s3_flush   <= r_s2_flags.flush_end;
            r_s3_changed <= n_area_changed;
            r_s3_lo      <= lo;
            r_s3_hi      <= hi;
            r_s3_miny    <= n_area_miny;
            r_s3_maxy    <= n_area_maxy;
        end
        if (r_s3_valid && r_s3_flush) begin
            r_s4_changed <= n_b_changed;
            r_s4_minx    <= n_b_minx;
            r_s4_maxx    <= n_b_maxx;
            r_s4_miny    <= n_b_miny;
            r_s4_maxy    <= n_b_maxy;
        end
    end

    always_comb begin
        o_res.region_x      = epdpdr_pkg::RX_W'(r_s4_minx);
        o_res.region_y      = epdpdr_pkg::RY_W'(r_s4_miny);
        o_res.region_width  = epdpdr_pkg::RW_W'(32'(r_s4_maxx) - 32'(r_s4_minx) + 32'd1);
        o_res.region_height = epdpdr_pkg::RH_W'(32'(r_s4_maxy) - 32'(r_s4_miny) + 32'd1);
    end

    assign o_res_valid = r_s4_valid && r_s4_changed;
    assign o_clearing  = r_clearing;
    assign o_inflight  = 2'(r_s2_valid && r_s2_flags.flush_end) +
                         2'(r_s3_valid && r_s3_flush) + 2'(r_s4_valid);

endmodule

>>> design/epd_pixel_diff_dirty_region_core.sv
// Top level of the e-paper pixel diff dirty-region tracker.
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  ----------------------------------------------
//  pixel     in   i_valid / o_ready    i_logical_x, i_logical_y, i_pixel_color,
//                                      i_area_end, i_flush_end
//  region    out  o_valid / i_ready    o_region_x, o_region_y, o_region_width,
//                                      o_region_height
//  config    in   i_cfg_we             i_cfg_idx, i_cfg_wdata
//
//  One pixel word is taken every cycle while o_ready is high; a pixel passes the
//  input queue and store stage to the frame store, and a flush result then the
//  closed-area and finished-box registers. The frame store is a dual-port 64-bit word
//  memory: one read and one write per cycle, with the last written word forwarded to
//  the read that follows it. After reset the store is swept to white, one word a
//  cycle over MEM_DEPTH words (6240 at 800 x 480), with o_ready low meanwhile.
//  A four-word queue parts front and back; a four-word result queue parts the back
//  from a stalled output, and a flush word enters the back only when it has room.
module epd_pixel_diff_dirty_region_core #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [epdpdr_pkg::LX_W-1:0]       i_logical_x,
    input  logic [epdpdr_pkg::LY_W-1:0]       i_logical_y,
    input  logic [epdpdr_pkg::COLOR_W-1:0]    i_pixel_color,
    input  logic                              i_area_end,
    input  logic                              i_flush_end,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [epdpdr_pkg::RX_W-1:0]       o_region_x,
    output logic [epdpdr_pkg::RY_W-1:0]       o_region_y,
    output logic [epdpdr_pkg::RW_W-1:0]       o_region_width,
    output logic [epdpdr_pkg::RH_W-1:0]       o_region_height,
    input  logic                              i_cfg_we,
    input  logic [epdpdr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [epdpdr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int PXW       = $clog2(PANEL_WIDTH + 1);
    localparam int PYW       = $clog2(PANEL_HEIGHT + 1);
    localparam int WS        = epdpdr_pkg::WORD_SEL;
    localparam int ROW_WORDS = (PANEL_WIDTH + epdpdr_pkg::WORD_BITS - 1) /
                               epdpdr_pkg::WORD_BITS;
    localparam int MEM_DEPTH = PANEL_HEIGHT * ROW_WORDS;
    localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int FLW       = $bits(epdpdr_pkg::t_pix_flags);
    localparam int QW        = FLW + PXW + PYW + MAW + WS;
    localparam int RW        = $bits(epdpdr_pkg::t_region);
    localparam int OCW       = $clog2(epdpdr_pkg::OUT_DEPTH + 1);

    logic       r_color_format;
    logic [7:0] r_black_threshold;

    epdpdr_pkg::t_pix_flags f_flags;
    logic [PXW-1:0]         f_px;
    logic [PYW-1:0]         f_py;
    logic [MAW-1:0]         f_addr;
    logic [WS-1:0]          f_bit;

    logic                   q_push;
    logic                   q_pop;
    logic                   q_empty;
    logic                   q_full;
    logic [QW-1:0]          q_wdata;
    logic [QW-1:0]          q_rdata;
    epdpdr_pkg::t_pix_flags h_flags;
    logic [PXW-1:0]         h_px;
    logic [PYW-1:0]         h_py;
    logic [MAW-1:0]         h_addr;
    logic [WS-1:0]          h_bit;

    logic                   clearing;
    logic [1:0]             inflight;
    logic                   res_valid;
    epdpdr_pkg::t_region    res;
    epdpdr_pkg::t_region    out_head;
    logic                   out_empty;
    logic                   out_full;
    logic [OCW-1:0]         out_count;
    logic                   out_pop;
    logic                   room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_format    <= epdpdr_pkg::COLOR_FORMAT_RESET;
            r_black_threshold <= epdpdr_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                epdpdr_pkg::CFG_COLOR_FORMAT: begin
                    r_color_format <= i_cfg_wdata[0];
                end
                epdpdr_pkg::CFG_BLACK_THRESHOLD: begin
                    r_black_threshold <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    epdpdr_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_logical_x       (i_logical_x),
        .i_logical_y       (i_logical_y),
        .i_pixel_color     (i_pixel_color),
        .i_area_end        (i_area_end),
        .i_flush_end       (i_flush_end),
        .i_color_format    (r_color_format),
        .i_black_threshold (r_black_threshold),
        .o_flags           (f_flags),
        .o_px              (f_px),
        .o_py              (f_py),
        .o_addr            (f_addr),
        .o_bit             (f_bit)
    );

    assign o_ready = !q_full && !clearing;
    assign q_push  = i_valid && o_ready;
    assign q_wdata = {f_flags, f_px, f_py, f_addr, f_bit};

    epdpdr_fifo #(
        .WIDTH (QW),
        .DEPTH (epdpdr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count ()
    );

    assign {h_flags, h_px, h_py, h_addr, h_bit} = q_rdata;

    // Hold a flush word back until its result is sure of a slot
    assign room  = ((OCW + 1)'(out_count) + (OCW + 1)'(inflight)) <
                   (OCW + 1)'(epdpdr_pkg::OUT_DEPTH);
    assign q_pop = !q_empty && !clearing && (!h_flags.flush_end || room);

    epdpdr_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_pop),
        .i_flags     (h_flags),
        .i_px        (h_px),
        .i_py        (h_py),
        .i_addr      (h_addr),
        .i_bit       (h_bit),
        .o_clearing  (clearing),
        .o_inflight  (inflight),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign out_pop = o_valid && i_ready;

    epdpdr_fifo #(
        .WIDTH (RW),
        .DEPTH (epdpdr_pkg::OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_wdata (res),
        .i_pop   (out_pop),
        .o_rdata (out_head),
        .o_empty (out_empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    assign o_valid         = !out_empty;
    assign o_region_x      = out_head.region_x;
    assign o_region_y      = out_head.region_y;
    assign o_region_width  = out_head.region_width;
    assign o_region_height = out_head.region_height;

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !out_full)
        else $error("region result pushed into a full result queue");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((OCW + 1)'(out_count) + (OCW + 1)'(inflight)) <=
        (OCW + 1)'(epdpdr_pkg::OUT_DEPTH))
        else $error("flush words in flight exceed result queue room");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!q_empty && !clearing))
        else $error("back end took a word from an empty queue or while clearing");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(clearing) |-> (q_empty && !res_valid))
        else $error("pixel traffic present before the store sweep finished");

endmodule
